[sv/idqs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idqs_pkg
// Shared types and codes for the integer deque with linear search.
// ----------------------------------------------------------------------------
package idqs_pkg;

  localparam int DATA_W   = 32;
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_SEARCH     = 3'd4,
    CMD_LIST       = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  // What one cell loads on the next edge
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_TAKE_LEFT,
    CELL_TAKE_RIGHT,
    CELL_LOAD
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_LIST
  } state_t;

endpackage

[sv/idqs_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idqs_cell
// One slot of the deque chain: holds an entry and takes it from a neighbour
// or from the input when told.
// ----------------------------------------------------------------------------
module idqs_cell import idqs_pkg::*; (
  input  logic              clk,
  input  cell_op_t          op,
  input  logic [DATA_W-1:0] left_data,
  input  logic [DATA_W-1:0] right_data,
  input  logic [DATA_W-1:0] load_data,
  output logic [DATA_W-1:0] data_q
);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;

  // Select the source for this slot
  always_comb begin
    case (op)
      CELL_TAKE_LEFT:  data_nxt = left_data;
      CELL_TAKE_RIGHT: data_nxt = right_data;
      CELL_LOAD:       data_nxt = load_data;
      default:         data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule

[sv/integer_deque_with_search.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_deque_with_search
// Bounded deque of signed 32-bit numbers held in a chain of cells, with
// linear search and an in-order listing.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive on the in_ stream (cmd and value_in in in_tdata), results
//   leave on the out_ stream (status and value_out in out_tdata, last on
//   out_tlast). Cell 0 holds the front entry while idle; pushes and pops shift
//   the chain, write at the back or shrink the count, one command per cycle,
//   and their single result is registered the cycle after the beat.
//   Search and list rotate the live entries through cell 0, one entry per
//   cycle while the output register is free; list gives one beat per entry
//   and search one beat at the end. The rotation always runs a full turn,
//   leaving the chain in its original order.
//   Unused command codes are dropped without a result.
//   A command is taken only when the block is idle and its output register
//   is free or being drained. When the receiver stalls, the output register
//   holds its beat and a list pauses its rotation until the beat is taken.
//   Reset empties the queue; stored entries need no clearing.
// ----------------------------------------------------------------------------
module integer_deque_with_search import idqs_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [2:0] cmd, [34:3] value_in
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [1:0] status, [33:2] value_out
  output logic                   out_tlast
);

  localparam int CW = $clog2(DEPTH + 1);

  // Chain of cells
  logic [DATA_W-1:0] cell_q   [DEPTH];
  logic [DATA_W-1:0] left_in  [DEPTH];
  logic [DATA_W-1:0] right_in [DEPTH];
  cell_op_t          cell_op  [DEPTH];

  // Control state
  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     walk_r, walk_nxt;
  logic              found_r, found_nxt;
  logic [DATA_W-1:0] key_r, key_nxt;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [DATA_W-1:0] out_value_r, out_value_nxt;
  logic              out_last_r, out_last_nxt;

  // Chain controls
  logic              shift_right;
  logic              shift_left;
  logic              rotate;
  logic              load_back;

  logic              out_free;
  logic              in_beat;
  cmd_t              cmd;
  logic [DATA_W-1:0] value_in;
  logic [CW-1:0]     cnt_m1;
  logic              is_full;
  logic              is_empty;

  assign cmd      = cmd_t'(in_tdata[CMD_W-1:0]);
  assign value_in = in_tdata[CMD_W +: DATA_W];
  assign out_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign in_beat  = in_tvalid && in_tready;
  assign cnt_m1   = count_r - CW'(1);
  assign is_full  = (count_r == CW'(DEPTH));
  assign is_empty = (count_r == '0);

  // Build the chain and its neighbour links
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_in[i] = value_in;
    end else begin : g_mid
      assign left_in[i] = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_in[i] = cell_q[0];
    end else begin : g_inner
      // Close the ring at the back entry while rotating
      assign right_in[i] = (rotate && (CW'(i) == cnt_m1)) ? cell_q[0] : cell_q[i+1];
    end

    always_comb begin
      if (shift_right) begin
        cell_op[i] = CELL_TAKE_LEFT;
      end else if (shift_left || rotate) begin
        cell_op[i] = CELL_TAKE_RIGHT;
      end else if (load_back && (CW'(i) == count_r)) begin
        cell_op[i] = CELL_LOAD;
      end else begin
        cell_op[i] = CELL_HOLD;
      end
    end

    idqs_cell u_cell (
      .clk        (clk),
      .op         (cell_op[i]),
      .left_data  (left_in[i]),
      .right_data (right_in[i]),
      .load_data  (value_in),
      .data_q     (cell_q[i])
    );
  end

  // Next state, chain controls and result
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    walk_nxt       = walk_r;
    found_nxt      = found_r;
    key_nxt        = key_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;
    shift_right    = 1'b0;
    shift_left     = 1'b0;
    rotate         = 1'b0;
    load_back      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          out_value_nxt = '0;
          out_last_nxt  = 1'b1;
          case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
              out_valid_nxt = 1'b1;
              if (is_full) begin
                out_status_nxt = STAT_FULL;
              end else begin
                out_status_nxt = STAT_OK;
                count_nxt      = count_r + CW'(1);
                shift_right    = (cmd == CMD_PUSH_FRONT);
                load_back      = (cmd == CMD_PUSH_BACK);
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
              out_valid_nxt = 1'b1;
              if (is_empty) begin
                out_status_nxt = STAT_EMPTY;
              end else begin
                out_status_nxt = STAT_OK;
                count_nxt      = cnt_m1;
                shift_left     = (cmd == CMD_POP_FRONT);
              end
            end
            CMD_SEARCH: begin
              if (is_empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STAT_NOT_FOUND;
              end else begin
                key_nxt   = value_in;
                walk_nxt  = '0;
                found_nxt = 1'b0;
                state_nxt = ST_SEARCH;
              end
            end
            CMD_LIST: begin
              if (is_empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STAT_EMPTY;
              end else begin
                walk_nxt  = '0;
                state_nxt = ST_LIST;
              end
            end
            default: begin
              // drop unused codes
            end
          endcase
        end
      end

      ST_SEARCH: begin
        // Compare the front cell and advance the ring
        if (out_free) begin
          rotate    = 1'b1;
          walk_nxt  = walk_r + CW'(1);
          found_nxt = found_r || (cell_q[0] == key_r);
          if (walk_r == cnt_m1) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = found_nxt ? STAT_OK : STAT_NOT_FOUND;
            out_value_nxt  = '0;
            out_last_nxt   = 1'b1;
            state_nxt      = ST_IDLE;
          end
        end
      end

      ST_LIST: begin
        // Emit the front cell and advance the ring
        if (out_free) begin
          rotate         = 1'b1;
          walk_nxt       = walk_r + CW'(1);
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_OK;
          out_value_nxt  = cell_q[0];
          out_last_nxt   = (walk_r == cnt_m1);
          if (walk_r == cnt_m1) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      walk_r      <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      walk_r      <= walk_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_TDATA_W - STATUS_W - DATA_W){1'b0}}, out_value_r, out_status_r};

endmodule
